// ===== rtl/core/rec_pkg.sv =====
// Shared constants, codes and channel types for the radial energy containment unit.
`timescale 1ns / 1ps

package rec_pkg;

	// Histogram geometry
	localparam int unsigned NUM_BINS  = 64;
	localparam int unsigned BIN_IDX_W = $clog2(NUM_BINS);
	localparam int unsigned CNT_W     = 7;

	// Field widths
	localparam int unsigned OP_W       = 2;
	localparam int unsigned POS_W      = 18;
	localparam int unsigned ENERGY_W   = 16;
	localparam int unsigned GRID_W     = 11;
	localparam int unsigned BW_W       = 16;
	localparam int unsigned RADIUS_W   = 22;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	// Datapath widths
	localparam int unsigned ACC_W  = 48;           // bin and total accumulators
	localparam int unsigned TGT_W  = ACC_W + 4;    // accumulator times 9 or 10
	localparam int unsigned SQ_W   = 2 * POS_W;    // one squared offset
	localparam int unsigned RAD_W  = SQ_W + 2;     // sum of two squares
	localparam int unsigned DIST_W = POS_W + 1;    // integer root of the sum
	localparam int unsigned EDGE_W = RADIUS_W + 1; // running bin edge, one bin of headroom

	// First trial bit of the root: highest even position inside the radicand
	localparam logic [RAD_W-1:0] SQRT_BIT0 = RAD_W'(1) << (RAD_W - 2);

	// Operation codes
	localparam logic [OP_W-1:0] OP_DEPOSIT = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR   = 2'd2;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_COUNT = 2'd2;

	// Register reset values
	localparam logic [GRID_W-1:0] GRID_RST = 11'd1;
	localparam logic [BW_W-1:0]   BW_RST   = 16'd256;
	localparam logic [CNT_W-1:0]  BC_RST   = 7'd64;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [POS_W-1:0]    pos_x;
		logic [POS_W-1:0]    pos_y;
		logic [ENERGY_W-1:0] energy;
	} req_t;

	typedef struct packed {
		logic [RADIUS_W-1:0] containment_radius;
		logic [CNT_W-1:0]    bin_reached;
		logic                found;
	} rsp_t;

endpackage

// ===== rtl/core/radial_energy_containment_unit.sv =====
// Radial cumulative energy histogram with a 90 percent containment radius query.
`timescale 1ns / 1ps

// Channel  Dir  Handshake               Payload
// req      in   req_valid / req_stall   rec_pkg::req_t (operation, pos_x, pos_y, energy)
// rsp      out  rsp_valid / rsp_stall   rec_pkg::rsp_t (containment_radius, bin_reached, found)
// cfg      in   cfg_valid / cfg_ready   cfg_index, cfg_data (grid_size, bin_width, bin_count)
//
// Deposit: squaring of both offsets on one multiplier, then the root unit (two radicand bits
// a cycle), then a read-modify-write walk over the n bins in use through the bin memory.
// Query: walk of up to n - 1 bins on the same memory port, stops at the first bin that
// holds 90 percent, then loads the output register. Clear completes without leaving idle.
// req_stall is high while a request is in work. The output register lets the next request
// in while a result waits; a stalled rsp holds only a finished query back from loading.
// Reset clears all bins at once through per-bin valid flags; no clearing pass.

module radial_energy_containment_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  req_valid,
	output logic                                  req_stall,
	input  rec_pkg::req_t                         req,
	output logic                                  rsp_valid,
	input  logic                                  rsp_stall,
	output rec_pkg::rsp_t                         rsp,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rec_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rec_pkg::CFG_DATA_W-1:0]        cfg_data
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQX  = 6'b000010,
		ST_SQY  = 6'b000100,
		ST_ROOT = 6'b001000,
		ST_WALK = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t state_q;

	// Configuration
	logic [rec_pkg::GRID_W-1:0] grid_q;
	logic [rec_pkg::BW_W-1:0]   bw_q;
	logic [rec_pkg::CNT_W-1:0]  bc_q;

	// Request context
	rec_pkg::req_t                  req_q;
	logic                           is_dep_q;
	logic [rec_pkg::POS_W-1:0]      centre_q;
	logic [rec_pkg::CNT_W-1:0]      n_q;
	logic [rec_pkg::BIN_IDX_W-1:0]  last_q;
	logic [rec_pkg::BW_W-1:0]       step_q;
	logic [rec_pkg::TGT_W-1:0]      target_q;

	// Distance unit
	logic [rec_pkg::RAD_W-1:0]  sum_q;
	logic [rec_pkg::RAD_W-1:0]  rad_q;
	logic [rec_pkg::RAD_W-1:0]  root_q;
	logic [rec_pkg::RAD_W-1:0]  bit_q;
	logic [rec_pkg::DIST_W-1:0] dist_q;

	// Bin walk
	logic [rec_pkg::EDGE_W-1:0]    edge_q;
	logic [rec_pkg::BIN_IDX_W-1:0] idx_q;
	logic                          issue_q;
	logic                          go_s1;
	logic [rec_pkg::BIN_IDX_W-1:0] idx_s1;
	logic [rec_pkg::ACC_W-1:0]     rdata_s1;
	logic                          vbit_s1;

	// Store
	logic [rec_pkg::ACC_W-1:0] bin_mem_q [rec_pkg::NUM_BINS];
	logic [rec_pkg::NUM_BINS-1:0] valid_q;
	logic [rec_pkg::ACC_W-1:0]    total_q;

	// Result
	rec_pkg::rsp_t res_q;
	rec_pkg::rsp_t rsp_q;
	logic          rsp_valid_q;

	// Combinational
	logic                          accept;
	logic                          rsp_load;
	logic [rec_pkg::CNT_W-1:0]     n_eff;
	logic [rec_pkg::GRID_W-1:0]    grid_m1;
	logic [rec_pkg::POS_W-1:0]     centre;
	logic [rec_pkg::BW_W-1:0]      step_in;
	logic [rec_pkg::CNT_W-1:0]     last_in;
	logic [rec_pkg::POS_W-1:0]     dx;
	logic [rec_pkg::POS_W-1:0]     dy;
	logic [rec_pkg::POS_W-1:0]     mul_a;
	logic [rec_pkg::SQ_W-1:0]      mul_p;
	logic [rec_pkg::RAD_W-1:0]     trial;
	logic                          take;
	logic [rec_pkg::RAD_W-1:0]     root_nx;
	logic [rec_pkg::ACC_W-1:0]     bin_s1;
	logic [rec_pkg::TGT_W-1:0]     bin_x10;
	logic                          hit;
	logic [rec_pkg::EDGE_W-1:0]    edge_nx;
	logic                          dep_hit;
	logic                          mem_we;
	logic [rec_pkg::ACC_W-1:0]     mem_wdata;
	logic                          s1_last;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;
	assign rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || !rsp_stall);

	// Effective bin count, clamped to 1..NUM_BINS
	always_comb begin
		if (bc_q == '0) begin
			n_eff = rec_pkg::CNT_W'(1);
		end else if (bc_q > rec_pkg::CNT_W'(rec_pkg::NUM_BINS)) begin
			n_eff = rec_pkg::CNT_W'(rec_pkg::NUM_BINS);
		end else begin
			n_eff = bc_q;
		end
	end

	// Grid centre in 1/256 cell units; empty grid puts it at zero
	assign grid_m1 = grid_q - rec_pkg::GRID_W'(1);
	assign centre  = (grid_q == '0) ? '0 : {grid_m1[rec_pkg::GRID_W-1:1], 8'd0};

	// Deposits walk with at least unit width; queries use the width as written
	assign step_in = (req.operation == rec_pkg::OP_DEPOSIT && bw_q == '0) ?
		rec_pkg::BW_W'(1) : bw_q;
	assign last_in = (req.operation == rec_pkg::OP_DEPOSIT) ?
		(n_eff - rec_pkg::CNT_W'(1)) : (n_eff - rec_pkg::CNT_W'(2));

	// Offsets and the shared squarer
	assign dx = (req_q.pos_x >= centre_q) ? (req_q.pos_x - centre_q) : (centre_q - req_q.pos_x);
	assign dy = (req_q.pos_y >= centre_q) ? (req_q.pos_y - centre_q) : (centre_q - req_q.pos_y);
	assign mul_a = (state_q == ST_SQX) ? dx : dy;
	assign mul_p = mul_a * mul_a;

	// One step of the digit-by-digit root
	assign trial   = root_q + bit_q;
	assign take    = (rad_q >= trial);
	assign root_nx = take ? ((root_q >> 1) + bit_q) : (root_q >> 1);

	// Bin stage: unwritten bins read as zero
	assign bin_s1  = vbit_s1 ? rdata_s1 : '0;
	assign bin_x10 = ({4'd0, bin_s1} << 3) + ({4'd0, bin_s1} << 1);
	assign hit     = (bin_x10 >= target_q);
	assign edge_nx = edge_q + rec_pkg::EDGE_W'(step_q);
	assign s1_last = (idx_s1 == last_q);

	// Bin i takes the energy when its upper edge (i+1)*w lies beyond the distance
	assign dep_hit   = (edge_q > rec_pkg::EDGE_W'(dist_q));
	assign mem_we    = (state_q == ST_WALK) && is_dep_q && go_s1 && dep_hit;
	assign mem_wdata = bin_s1 + rec_pkg::ACC_W'(req_q.energy);

	// Control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			go_s1       <= 1'b0;
			valid_q     <= '0;
			total_q     <= '0;
			rsp_valid_q <= 1'b0;
			grid_q      <= rec_pkg::GRID_RST;
			bw_q        <= rec_pkg::BW_RST;
			bc_q        <= rec_pkg::BC_RST;
		end else begin
			// Register writes
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					rec_pkg::CFG_GRID_SIZE: grid_q <= cfg_data[rec_pkg::GRID_W-1:0];
					rec_pkg::CFG_BIN_WIDTH: bw_q   <= cfg_data[rec_pkg::BW_W-1:0];
					rec_pkg::CFG_BIN_COUNT: bc_q   <= cfg_data[rec_pkg::CNT_W-1:0];
					default: ;
				endcase
			end

			// Output register
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			if (mem_we) begin
				valid_q[idx_s1] <= 1'b1;
			end

			// Sequencer
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						go_s1 <= 1'b0;
						unique case (req.operation)
							rec_pkg::OP_DEPOSIT: state_q <= ST_SQX;
							rec_pkg::OP_QUERY: begin
								if (n_eff == rec_pkg::CNT_W'(1)) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_WALK;
									issue_q <= 1'b1;
								end
							end
							rec_pkg::OP_CLEAR: begin
								valid_q <= '0;
								total_q <= '0;
							end
							default: ;
						endcase
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: state_q <= ST_ROOT;
				ST_ROOT: begin
					if (bit_q[0]) begin
						state_q <= ST_WALK;
						issue_q <= 1'b1;
						go_s1   <= 1'b0;
					end
				end
				ST_WALK: begin
					// issue side
					go_s1 <= issue_q;
					if (issue_q && idx_q == last_q) begin
						issue_q <= 1'b0;
					end
					// update side
					if (go_s1) begin
						if (is_dep_q) begin
							if (s1_last) begin
								total_q <= total_q + rec_pkg::ACC_W'(req_q.energy);
								state_q <= ST_IDLE;
							end
						end else if (hit || s1_last) begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_DONE: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					req_q    <= req;
					is_dep_q <= (req.operation == rec_pkg::OP_DEPOSIT);
					centre_q <= centre;
					n_q      <= n_eff;
					last_q   <= last_in[rec_pkg::BIN_IDX_W-1:0];
					step_q   <= step_in;
					target_q <= ({4'd0, total_q} << 3) + {4'd0, total_q};
					edge_q   <= rec_pkg::EDGE_W'(step_in);
					idx_q    <= '0;
					// single-bin query: nothing to test
					res_q.containment_radius <= rec_pkg::RADIUS_W'(step_in);
					res_q.bin_reached        <= rec_pkg::CNT_W'(1);
					res_q.found              <= 1'b0;
				end
			end
			ST_SQX: sum_q <= rec_pkg::RAD_W'(mul_p);
			ST_SQY: begin
				rad_q  <= sum_q + rec_pkg::RAD_W'(mul_p);
				root_q <= '0;
				bit_q  <= rec_pkg::SQRT_BIT0;
			end
			ST_ROOT: begin
				if (take) begin
					rad_q <= rad_q - trial;
				end
				root_q <= root_nx;
				bit_q  <= bit_q >> 2;
				if (bit_q[0]) begin
					dist_q <= root_nx[rec_pkg::DIST_W-1:0];
				end
			end
			ST_WALK: begin
				vbit_s1 <= valid_q[idx_q];
				if (issue_q) begin
					idx_s1 <= idx_q;
					if (idx_q != last_q) begin
						idx_q <= idx_q + rec_pkg::BIN_IDX_W'(1);
					end
				end
				if (go_s1) begin
					edge_q <= edge_nx;
					if (!is_dep_q) begin
						if (hit) begin
							res_q.containment_radius <= edge_q[rec_pkg::RADIUS_W-1:0];
							res_q.bin_reached <= rec_pkg::CNT_W'(idx_s1) + rec_pkg::CNT_W'(1);
							res_q.found       <= 1'b1;
						end else if (s1_last) begin
							res_q.containment_radius <= edge_nx[rec_pkg::RADIUS_W-1:0];
							res_q.bin_reached        <= n_q;
							res_q.found              <= 1'b0;
						end
					end
				end
			end
			ST_DONE: ;
			default: ;
		endcase
	end

	// Bin memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			bin_mem_q[idx_s1] <= mem_wdata;
		end
		rdata_s1 <= bin_mem_q[idx_q];
	end

	// Deposits and queries keep the block busy on the next cycle
	a_busy_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.operation == rec_pkg::OP_DEPOSIT ||
			req.operation == rec_pkg::OP_QUERY)) |=> req_stall)
		else $error("request in work but input not stalled");

	// The update stage never runs past the last bin of the walk
	a_walk_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && go_s1) |-> (idx_s1 <= last_q))
		else $error("bin walk beyond last bin");

	// Only queries produce results
	a_done_is_query: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |-> !is_dep_q)
		else $error("deposit reached result state");

	// A delivered bin edge index is one-based and within the store
	a_reached_range: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> (rsp_q.bin_reached != '0 &&
			rsp_q.bin_reached <= rec_pkg::CNT_W'(rec_pkg::NUM_BINS)))
		else $error("bin_reached out of range");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the radial energy containment unit.
`timescale 1ns / 1ps

module tb;
	import rec_pkg::*;

	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	localparam longint unsigned POS_MAX = (64'd1 << POS_W) - 1;
	localparam int PHASES = 10;
	localparam int PHASE_REQUESTS = 143;
	localparam int SETTLE_CYCLES = 120;
	localparam int HOLD_CYCLES = 1500;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow geometry and histogram
	logic [GRID_W-1:0] cfg_grid_size = GRID_RST;
	logic [BW_W-1:0] cfg_bin_width = BW_RST;
	logic [CNT_W-1:0] cfg_bin_count = BC_RST;
	logic [ACC_W-1:0] energy_bins [NUM_BINS];
	logic [ACC_W-1:0] energy_total = '0;

	req_t hits_to_send [$];
	rsp_t expected_radii [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic pressure_start = 1'b0;
	int pressure_left = 0;

	radial_energy_containment_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		for (int b = 0; b < NUM_BINS; b++) begin
			energy_bins[b] = '0;
		end
	end

	// Bins in use after clamping the count register
	function automatic int active_bins();
		if (cfg_bin_count == 0) return 1;
		if (cfg_bin_count > NUM_BINS) return NUM_BINS;
		return int'(cfg_bin_count);
	endfunction

	function automatic longint unsigned grid_centre();
		if (cfg_grid_size == 0) return 0;
		return ((longint'(cfg_grid_size) - 1) >> 1) * 256;
	endfunction

	// Floor of the square root, one result bit at a time
	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned r;
		longint unsigned t;
		r = 0;
		for (int b = 20; b >= 0; b--) begin
			t = r | (64'd1 << b);
			if (t * t <= v) r = t;
		end
		return r;
	endfunction

	// Apply one request to the shadow histogram; queries leave an expected radius
	task automatic track_histogram(input req_t r);
		longint unsigned dx, dy, distance, width, first_bin, target, bin_sum;
		int n;
		rsp_t res;
		n = active_bins();
		case (r.operation)
			OP_DEPOSIT: begin
				dx = (r.pos_x >= grid_centre()) ? r.pos_x - grid_centre() : grid_centre() - r.pos_x;
				dy = (r.pos_y >= grid_centre()) ? r.pos_y - grid_centre() : grid_centre() - r.pos_y;
				distance = root_floor(dx * dx + dy * dy);
				width = (cfg_bin_width == 0) ? 1 : cfg_bin_width;
				first_bin = distance / width;
				for (int b = 0; b < n; b++) begin
					if (b >= first_bin) energy_bins[b] = energy_bins[b] + r.energy;
				end
				energy_total = energy_total + r.energy;
			end
			OP_QUERY: begin
				target = longint'(energy_total) * 9;
				res.found = 1'b0;
				res.bin_reached = CNT_W'(n);
				res.containment_radius = RADIUS_W'(longint'(n) * cfg_bin_width);
				for (int b = 0; b + 1 < n; b++) begin
					bin_sum = longint'(energy_bins[b]) * 10;
					if (!res.found && bin_sum >= target) begin
						res.found = 1'b1;
						res.bin_reached = CNT_W'(b + 1);
						res.containment_radius = RADIUS_W'(longint'(b + 1) * cfg_bin_width);
					end
				end
				expected_radii.push_back(res);
			end
			OP_CLEAR: begin
				for (int b = 0; b < NUM_BINS; b++) begin
					energy_bins[b] = '0;
				end
				energy_total = '0;
			end
			default: begin
			end
		endcase
	endtask

	// Request driver: hold while stalled, otherwise maybe present the next one
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_valid && !req_stall) track_histogram(req);
			if (!req_valid || !req_stall) begin
				if (hits_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					req <= hits_to_send.pop_front();
					req_valid <= 1'b1;
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Long receiver hold-off
	always @(posedge clk) begin
		if (pressure_start) begin
			pressure_left <= HOLD_CYCLES;
		end else if (pressure_left != 0) begin
			pressure_left <= pressure_left - 1;
		end
	end

	// Result monitor and checker
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_radii.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result, expected none, actual %p", $time, rsp);
				end else begin
					want = expected_radii.pop_front();
					if (rsp.containment_radius !== want.containment_radius) begin
						mismatches++;
						$display("%0t: containment_radius expected %0d actual %0d", $time,
							want.containment_radius, rsp.containment_radius);
					end
					if (rsp.bin_reached !== want.bin_reached) begin
						mismatches++;
						$display("%0t: bin_reached expected %0d actual %0d", $time,
							want.bin_reached, rsp.bin_reached);
					end
					if (rsp.found !== want.found) begin
						mismatches++;
						$display("%0t: found expected %0d actual %0d", $time, want.found, rsp.found);
					end
				end
			end
			rsp_stall <= (pressure_left != 0) || ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic req_t make_request(input logic [OP_W-1:0] op, input longint unsigned x,
		input longint unsigned y, input longint unsigned e);
		req_t r;
		r.operation = op;
		r.pos_x = POS_W'(x);
		r.pos_y = POS_W'(y);
		r.energy = ENERGY_W'(e);
		return r;
	endfunction

	// Coordinate within span of the centre, clamped to the field
	function automatic longint unsigned near_centre(input longint unsigned span);
		longint p;
		p = longint'(grid_centre());
		if ($urandom_range(1)) p = p + $urandom_range(int'(span));
		else p = p - $urandom_range(int'(span));
		if (p < 0) p = 0;
		if (p > longint'(POS_MAX)) p = POS_MAX;
		return p;
	endfunction

	function automatic req_t random_request();
		req_t r;
		int pick;
		longint unsigned span;
		pick = $urandom_range(99);
		r.operation = (pick < 74) ? OP_DEPOSIT : (pick < 90) ? OP_QUERY :
			(pick < 93) ? OP_CLEAR : OP_UNUSED;
		span = longint'(active_bins()) * ((cfg_bin_width == 0) ? 1 : cfg_bin_width);
		if (span > POS_MAX) span = POS_MAX;
		if ($urandom_range(3) == 0) begin
			r.pos_x = POS_W'($urandom);
			r.pos_y = POS_W'($urandom);
		end else begin
			r.pos_x = POS_W'(near_centre(span));
			r.pos_y = POS_W'(near_centre(span));
		end
		r.energy = $urandom_range(1) ? ENERGY_W'($urandom) : ENERGY_W'($urandom_range(15));
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_GRID_SIZE: cfg_grid_size = val[GRID_W-1:0];
			CFG_BIN_WIDTH: cfg_bin_width = val[BW_W-1:0];
			CFG_BIN_COUNT: cfg_bin_count = val[CNT_W-1:0];
			default: begin
			end
		endcase
	endtask

	task automatic program_geometry(input logic [CFG_DATA_W-1:0] grid,
		input logic [CFG_DATA_W-1:0] width, input logic [CFG_DATA_W-1:0] count);
		write_reg(CFG_GRID_SIZE, grid);
		write_reg(CFG_BIN_WIDTH, width);
		write_reg(CFG_BIN_COUNT, count);
	endtask

	// Wait for every request and result, then for a deposit still in work
	task automatic drain();
		while (hits_to_send.size() != 0 || req_valid || expected_radii.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		logic [CFG_DATA_W-1:0] geo [PHASES][3];
		int sent;
		req_t r;
		geo = '{'{1024, 256, 64}, '{100, 64, 8}, '{513, 1000, 32}, '{0, 0, 0},
			'{2047, 65535, 64}, '{1, 1, 2}, '{0, 0, 0}, '{0, 0, 127}, '{64, 300, 1}, '{0, 0, 0}};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: reset geometry, empty store, ignored op, field extremes, clear
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		hits_to_send.push_back(make_request(OP_UNUSED, POS_MAX, POS_MAX, 65535));
		hits_to_send.push_back(make_request(OP_DEPOSIT, 0, 0, 0));
		hits_to_send.push_back(make_request(OP_DEPOSIT, 0, 0, 65535));
		hits_to_send.push_back(make_request(OP_DEPOSIT, POS_MAX, POS_MAX, 65535));
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		hits_to_send.push_back(make_request(OP_DEPOSIT, 10 * 256, 0, 1234));
		hits_to_send.push_back(make_request(OP_QUERY, POS_MAX, 0, 65535));
		hits_to_send.push_back(make_request(OP_CLEAR, 0, 0, 0));
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		drain();
		// Zero grid, zero width, zero count
		program_geometry(0, 0, 0);
		hits_to_send.push_back(make_request(OP_DEPOSIT, 3, 4, 100));
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		drain();
		// Oversized count, widest bins: full-scale radius
		program_geometry(2047, 65535, 127);
		hits_to_send.push_back(make_request(OP_DEPOSIT, 0, 0, 65535));
		hits_to_send.push_back(make_request(OP_DEPOSIT, POS_MAX, 0, 7));
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		drain();
		program_geometry(1024, 1, 1);
		hits_to_send.push_back(make_request(OP_DEPOSIT, 130816, 130816, 9));
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		drain();
		program_geometry(5, 3, 2);
		hits_to_send.push_back(make_request(OP_DEPOSIT, 512, 512, 500));
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		hits_to_send.push_back(make_request(OP_DEPOSIT, 520, 512, 40000));
		hits_to_send.push_back(make_request(OP_QUERY, 0, 0, 0));
		drain();

		// Random phases, one geometry each
		for (int ph = 0; ph < PHASES; ph++) begin
			if (ph < 4) begin
				send_idle_pct = 27;
				recv_stall_pct = 77;
			end else if (ph < 7) begin
				send_idle_pct = 77;
				recv_stall_pct = 27;
			end else begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			if (geo[ph][1] == 0 && ph != 7) begin
				program_geometry(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(4096)),
					CFG_DATA_W'($urandom));
			end else begin
				program_geometry(geo[ph][0], geo[ph][1], geo[ph][2]);
			end
			sent = 0;
			while (sent < PHASE_REQUESTS) begin
				r = random_request();
				hits_to_send.push_back(r);
				sent++;
			end
			if (ph == 2) begin
				@(posedge clk);
				pressure_start <= 1'b1;
				@(posedge clk);
				pressure_start <= 1'b0;
			end
			drain();
		end

		if (mismatches == 0) begin
			$display("** radial_energy_containment_unit: PASSED **");
		end else begin
			$display("** radial_energy_containment_unit: FAILED **");
		end
		$finish;
	end

	// Watchdog
	initial begin
		#2000000;
		$display("** radial_energy_containment_unit: FAILED **");
		$finish;
	end

endmodule
